>>> hw/rtl/jtmf_pkg.sv
// shared types and constants for the json top-level member finder
package jtmf_pkg;

  localparam int unsigned KEY_TEXT_W = 64;
  localparam int unsigned KEY_LEN_W  = 4;
  localparam int unsigned SPAN_W     = 12;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_TEXT   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LENGTH = 1'd1;

  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_COMMA  = 8'h2c;
  localparam logic [7:0] CH_COLON  = 8'h3a;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } jtmf_beat_t;

  typedef struct packed {
    logic              found;
    logic [SPAN_W-1:0] span_begin;
    logic [SPAN_W-1:0] span_end;
  } jtmf_result_t;

endpackage

>>> hw/rtl/json_top_level_member_finder.sv
// top level of the json top-level member finder
// Scans one JSON line per packet, one byte beat per cycle, and returns one result beat per
// line telling whether the top-level member with the configured key was found, with the
// offset of its key's opening quote and of the byte ending its value. A new byte is taken
// every cycle while the output is not stalled; a byte passes through an input register and
// the scan logic into the result register. The rate of one byte per cycle is set by the scan
// state registers, which are updated once per byte.
// Configure key_text and key_length only between lines.
module json_top_level_member_finder
  import jtmf_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 4096,
  parameter int unsigned MAX_DEPTH  = 255,
  parameter int unsigned KEY_BYTES  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_TEXT_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_found,
  output logic [SPAN_W-1:0]     out_span_begin,
  output logic [SPAN_W-1:0]     out_span_end
);

  jtmf_beat_t   in_beat;
  jtmf_beat_t   beat;
  logic         beat_valid;
  logic         step;
  logic         res_valid;
  jtmf_result_t res;
  jtmf_result_t out_res;

  assign in_beat.data_byte = in_data_byte;
  assign in_beat.last_byte = in_last_byte;

  assign step = beat_valid && (!out_valid || out_ready);

  jtmf_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_beat    (in_beat),
    .advance    (step),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  jtmf_scan_core #(
    .LINE_BYTES (LINE_BYTES),
    .MAX_DEPTH  (MAX_DEPTH),
    .KEY_BYTES  (KEY_BYTES)
  ) u_scan_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (step),
    .beat      (beat),
    .res_valid (res_valid),
    .res       (res)
  );

  jtmf_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .res_valid (res_valid),
    .res       (res),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_found      = out_res.found;
  assign out_span_begin = out_res.span_begin;
  assign out_span_end   = out_res.span_end;

endmodule

>>> hw/rtl/jtmf_in_stage.sv
// input register stage holding one byte beat ahead of the scanner
module jtmf_in_stage
  import jtmf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  jtmf_beat_t in_beat,
  input  logic       advance,
  output logic       beat_valid,
  output jtmf_beat_t beat
);

  logic       valid_r;
  logic       valid_nxt;
  jtmf_beat_t beat_r;
  logic       take;

  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r && !advance;
    if (take) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      beat_r <= in_beat;
    end
  end

  assign beat_valid = valid_r;
  assign beat       = beat_r;

endmodule

>>> hw/rtl/jtmf_scan_core.sv
// line scan state, key compare and per-byte decision logic
module jtmf_scan_core
  import jtmf_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 4096,
  parameter int unsigned MAX_DEPTH  = 255,
  parameter int unsigned KEY_BYTES  = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [KEY_TEXT_W-1:0] cfg_data,
  input  logic                  step,
  input  jtmf_beat_t            beat,
  output logic                  res_valid,
  output jtmf_result_t          res
);

  localparam int unsigned POS_W   = $clog2(LINE_BYTES + 1);
  localparam int unsigned DEPTH_W = $clog2(MAX_DEPTH + 1);

  localparam logic [2:0] PH_OPEN     = 3'd0;
  localparam logic [2:0] PH_MEMBER   = 3'd1;
  localparam logic [2:0] PH_KEY      = 3'd2;
  localparam logic [2:0] PH_KEY_ESC  = 3'd3;
  localparam logic [2:0] PH_COLON    = 3'd4;
  localparam logic [2:0] PH_VALUE    = 3'd5;
  localparam logic [2:0] PH_VSTR     = 3'd6;
  localparam logic [2:0] PH_VSTR_ESC = 3'd7;

  logic [KEY_TEXT_W-1:0] key_text_r;
  logic [KEY_LEN_W-1:0]  key_length_r;

  logic [2:0]           phase_r,     phase_nxt;
  logic [POS_W-1:0]     pos_r,       pos_nxt;
  logic [DEPTH_W-1:0]   depth_r,     depth_nxt;
  logic [POS_W-1:0]     key_start_r, key_start_nxt;
  logic [KEY_LEN_W-1:0] key_index_r, key_index_nxt;
  logic                 differs_r,   differs_nxt;
  logic                 outcome_r,   outcome_nxt;

  logic                 decided;
  logic                 hit;
  logic [POS_W-1:0]     end_pos;
  logic                 char_differs;
  logic [KEY_LEN_W-1:0] index_bumped;
  logic [7:0]           key_byte;
  logic [7:0]           c;
  logic [POS_W+SPAN_W-1:0] begin_ext;
  logic [POS_W+SPAN_W-1:0] end_ext;

  assign c        = beat.data_byte;
  assign key_byte = key_text_r[{key_index_r[2:0], 3'b000} +: 8];

  always_comb begin
    char_differs = 1'b0;
    if (key_index_r >= key_length_r || key_index_r >= KEY_LEN_W'(KEY_BYTES)) begin
      char_differs = 1'b1;
    end else if (key_byte != c) begin
      char_differs = 1'b1;
    end
    index_bumped = (key_index_r < {KEY_LEN_W{1'b1}}) ? key_index_r + 1'b1 : key_index_r;
  end

  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    depth_nxt     = depth_r;
    key_start_nxt = key_start_r;
    key_index_nxt = key_index_r;
    differs_nxt   = differs_r;
    decided       = 1'b0;
    hit           = 1'b0;
    end_pos       = '0;

    if (!outcome_r) begin
      if (pos_r >= POS_W'(LINE_BYTES)) begin
        decided = 1'b1;
      end else begin
        case (phase_r)
          PH_OPEN: begin
            if (c != CH_LBRACE) begin
              decided = 1'b1;
            end else begin
              phase_nxt = PH_MEMBER;
            end
          end
          PH_MEMBER: begin
            if (c != CH_QUOTE) begin
              decided = 1'b1;
            end else begin
              key_start_nxt = pos_r;
              key_index_nxt = '0;
              differs_nxt   = 1'b0;
              phase_nxt     = PH_KEY;
            end
          end
          PH_KEY: begin
            if (c == CH_QUOTE) begin
              if (key_index_r != key_length_r || key_length_r > KEY_LEN_W'(KEY_BYTES)) begin
                differs_nxt = 1'b1;
              end
              phase_nxt = PH_COLON;
            end else begin
              differs_nxt   = differs_r | char_differs;
              key_index_nxt = index_bumped;
              if (c == CH_BSLASH) begin
                phase_nxt = PH_KEY_ESC;
              end
            end
          end
          PH_KEY_ESC: begin
            differs_nxt   = differs_r | char_differs;
            key_index_nxt = index_bumped;
            phase_nxt     = PH_KEY;
          end
          PH_COLON: begin
            if (c != CH_COLON) begin
              decided = 1'b1;
            end else begin
              depth_nxt = '0;
              phase_nxt = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (c == CH_QUOTE) begin
              phase_nxt = PH_VSTR;
            end else if (c == CH_LBRACE || c == CH_LBRACK) begin
              if (depth_r >= DEPTH_W'(MAX_DEPTH)) begin
                decided = 1'b1;
              end else begin
                depth_nxt = depth_r + 1'b1;
              end
            end else if (c == CH_RBRACE || c == CH_RBRACK) begin
              if (depth_r == '0) begin
                decided = 1'b1;
                hit     = !differs_r;
                end_pos = pos_r;
              end else begin
                depth_nxt = depth_r - 1'b1;
              end
            end else if (c == CH_COMMA && depth_r == '0) begin
              if (!differs_r) begin
                decided = 1'b1;
                hit     = 1'b1;
                end_pos = pos_r;
              end else begin
                phase_nxt = PH_MEMBER;
              end
            end
          end
          PH_VSTR: begin
            if (c == CH_BSLASH) begin
              phase_nxt = PH_VSTR_ESC;
            end else if (c == CH_QUOTE) begin
              phase_nxt = PH_VALUE;
            end
          end
          PH_VSTR_ESC: begin
            phase_nxt = PH_VSTR;
          end
          default: begin
            decided = 1'b1;
          end
        endcase
      end
      if (beat.last_byte) begin
        decided = 1'b1;
      end
    end

    outcome_nxt = outcome_r | decided;
    if (pos_r < POS_W'(LINE_BYTES)) begin
      pos_nxt = pos_r + 1'b1;
    end

    // end of line returns all line state to its start
    if (beat.last_byte) begin
      phase_nxt     = PH_OPEN;
      pos_nxt       = '0;
      depth_nxt     = '0;
      key_start_nxt = '0;
      key_index_nxt = '0;
      differs_nxt   = 1'b0;
      outcome_nxt   = 1'b0;
    end
  end

  assign begin_ext = {{SPAN_W{1'b0}}, key_start_r};
  assign end_ext   = {{SPAN_W{1'b0}}, end_pos};

  assign res_valid      = step && decided;
  assign res.found      = hit;
  assign res.span_begin = hit ? begin_ext[SPAN_W-1:0] : '0;
  assign res.span_end   = hit ? end_ext[SPAN_W-1:0] : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_text_r   <= '0;
      key_length_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_TEXT:   key_text_r   <= cfg_data;
        CFG_KEY_LENGTH: key_length_r <= cfg_data[KEY_LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPEN;
      pos_r       <= '0;
      depth_r     <= '0;
      key_start_r <= '0;
      key_index_r <= '0;
      differs_r   <= 1'b0;
      outcome_r   <= 1'b0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      depth_r     <= depth_nxt;
      key_start_r <= key_start_nxt;
      key_index_r <= key_index_nxt;
      differs_r   <= differs_nxt;
      outcome_r   <= outcome_nxt;
    end
  end

endmodule

>>> hw/rtl/jtmf_out_stage.sv
// result register holding one beat for the output channel
module jtmf_out_stage
  import jtmf_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         step,
  input  logic         res_valid,
  input  jtmf_result_t res,
  output logic         out_valid,
  input  logic         out_ready,
  output jtmf_result_t out_res
);

  logic         valid_r;
  logic         valid_nxt;
  jtmf_result_t res_r;

  always_comb begin
    valid_nxt = valid_r && !out_ready;
    if (step) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

>>> hw/rtl/jtmf_checker.sv
// port-level checks for the json top-level member finder and their binding
module jtmf_checker
  import jtmf_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic              out_found,
  input logic [SPAN_W-1:0] out_span_begin,
  input logic [SPAN_W-1:0] out_span_end
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_found)
      && $stable(out_span_begin) && $stable(out_span_end))
    else $error("result beat changed while stalled");

  // a miss carries zero offsets
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_span_begin == '0 && out_span_end == '0)
    else $error("not-found result with nonzero offsets");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind json_top_level_member_finder jtmf_checker u_jtmf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_found      (out_found),
  .out_span_begin (out_span_begin),
  .out_span_end   (out_span_end)
);
